FILE: hdl/pcbs_pkg.sv
`timescale 1ns / 1ps

package pcbs_pkg;

    // Storage depth of the background memory and the widths that follow from it.
    localparam int MAX_POINTS = 262144;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;

    // Fixed field widths.
    localparam int COORD_W  = 16;
    localparam int COLOUR_W = 24;
    localparam int INDEX_W  = 20;
    localparam int THR_W    = 16;
    localparam int SIDE_W   = 11;
    localparam int T2_W     = 2 * THR_W;
    localparam int BG_W     = 3 * COORD_W + 1;

    localparam int SIDE_MAX = 1024;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(600);
    localparam logic [SIDE_W-1:0] WIDTH_RESET  = SIDE_W'(640);
    localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(360);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_pcbs_reg;

    // Control word that moves along the pipeline. In the read stage the flag
    // means "compare against the background"; after the distance test it
    // means "foreground point, emit it".
    typedef struct packed {
        logic valid;
        logic flag;
    } t_pcbs_ctl;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(SIDE_MAX)) begin
            r = SIDE_W'(SIDE_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/pcbs_dist.sv
`timescale 1ns / 1ps

module pcbs_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  pcbs_pkg::t_pcbs_ctl                  i_ctl,
    input  logic signed [pcbs_pkg::COORD_W-1:0]  i_cur_x,
    input  logic signed [pcbs_pkg::COORD_W-1:0]  i_cur_y,
    input  logic signed [pcbs_pkg::COORD_W-1:0]  i_cur_z,
    input  logic [pcbs_pkg::BG_W-1:0]            i_bg,
    input  logic [pcbs_pkg::T2_W-1:0]            i_t2,
    output pcbs_pkg::t_pcbs_ctl                  o_ctl
);
    import pcbs_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int SUM_W  = SQ_W + 2;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0]        ax, ay, az;
    logic [SQ_W-1:0]          sq_x, sq_y, sq_z;
    logic [SUM_W-1:0]         sum;

    t_pcbs_ctl       r_ctl;
    logic [SQ_W-1:0] r_sq_x, r_sq_y, r_sq_z;

    // Differences need one extra bit; their magnitude always fits in 16 bits.
    always_comb begin
        dx = {i_cur_x[COORD_W-1], i_cur_x}
           - {i_bg[COORD_W-1], i_bg[COORD_W-1:0]};
        dy = {i_cur_y[COORD_W-1], i_cur_y}
           - {i_bg[2*COORD_W-1], i_bg[2*COORD_W-1:COORD_W]};
        dz = {i_cur_z[COORD_W-1], i_cur_z}
           - {i_bg[3*COORD_W-1], i_bg[3*COORD_W-1:2*COORD_W]};
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        sq_x = SQ_W'(ax[COORD_W-1:0]) * SQ_W'(ax[COORD_W-1:0]);
        sq_y = SQ_W'(ay[COORD_W-1:0]) * SQ_W'(ay[COORD_W-1:0]);
        sq_z = SQ_W'(az[COORD_W-1:0]) * SQ_W'(az[COORD_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
            r_ctl.flag  <= i_ctl.flag && i_bg[3*COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x <= sq_x;
            r_sq_y <= sq_y;
            r_sq_z <= sq_z;
        end
    end

    assign sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    always_comb begin
        o_ctl.valid = r_ctl.valid;
        o_ctl.flag  = r_ctl.flag && (sum > SUM_W'(i_t2));
    end

endmodule

FILE: hdl/point_cloud_background_subtract.sv
`timescale 1ns / 1ps

// Point-cloud background subtraction. Points of an organized cloud enter one
// per transfer in raster order; the first whole frame after reset is stored
// as the background (coordinates plus a validity bit per position) and
// produces no output. In every later frame a point is sent out, with its
// colour and raster index, when both it and the stored point at the same
// position are valid and the squared distance between them is greater than
// the squared threshold. The block takes one point per clock while the
// output is not stalled. Each point passes in order through the three
// register stages: the background memory read, the per-axis squaring,
// and the sum and compare into the output register that presents its
// result on the output ports. The only stall comes from the
// output: while a result is held there, the whole pipeline and the input
// stall with it. The frame size is width times height, each side limited to
// 1..1024 and the product to the memory depth. The background memory is not
// cleared after reset; the capture frame fills it, so there is no start-up
// delay. Configuration writes are accepted at any time but must only be
// issued while the block is idle; they do not disturb the stored background
// or the frame position.
module point_cloud_background_subtract (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Point input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [pcbs_pkg::COORD_W-1:0]    i_pos_x,
    input  logic signed [pcbs_pkg::COORD_W-1:0]    i_pos_y,
    input  logic signed [pcbs_pkg::COORD_W-1:0]    i_pos_z,
    input  logic [pcbs_pkg::COLOUR_W-1:0]          i_colour,
    input  logic                                   i_finite,
    // Foreground output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pcbs_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [pcbs_pkg::COORD_W-1:0]    o_out_y,
    output logic signed [pcbs_pkg::COORD_W-1:0]    o_out_z,
    output logic [pcbs_pkg::COLOUR_W-1:0]          o_out_colour,
    output logic [pcbs_pkg::INDEX_W-1:0]           o_point_index,
    // Configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pcbs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcbs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import pcbs_pkg::*;

    localparam int PROD_W = 2 * SIDE_W;

    // Configuration registers and the squared threshold derived from them.
    logic [THR_W-1:0]  r_threshold;
    logic [SIDE_W-1:0] r_frame_width;
    logic [SIDE_W-1:0] r_frame_height;
    logic [T2_W-1:0]   r_t2;

    // Frame position and capture state.
    logic [ADDR_W-1:0] r_count;
    logic              r_bg_ready;

    // Background memory with its registered read port.
    logic [BG_W-1:0]   r_bg_mem [MAX_POINTS];
    logic [BG_W-1:0]   r_bg_rd;

    // Read stage: the point whose background entry is being fetched.
    t_pcbs_ctl            r_s1_ctl;
    logic [COORD_W-1:0]   r_s1_x, r_s1_y, r_s1_z;
    logic [COLOUR_W-1:0]  r_s1_colour;
    logic [ADDR_W-1:0]    r_s1_idx;

    // Distance stage: payload carried alongside the squaring registers.
    t_pcbs_ctl            s2_ctl;
    logic [COORD_W-1:0]   r_s2_x, r_s2_y, r_s2_z;
    logic [COLOUR_W-1:0]  r_s2_colour;
    logic [ADDR_W-1:0]    r_s2_idx;

    // Output register.
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x, r_out_y, r_out_z;
    logic [COLOUR_W-1:0]  r_out_colour;
    logic [ADDR_W-1:0]    r_out_idx;

    logic [PROD_W-1:0]    side_prod;
    logic [CNT_W-1:0]     npts;
    logic [ADDR_W-1:0]    cur_idx;
    logic [CNT_W-1:0]     nxt_idx;
    logic                 wrap;
    logic                 en;
    logic                 accept;

    // The whole pipeline moves whenever the output register is free or is
    // being emptied in this cycle; a held result stalls everything behind it.
    assign en          = !r_out_valid || !i_out_stall;
    assign accept      = i_in_valid && en;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes. An index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THR_RESET;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_threshold    <= i_cfg_data[THR_W-1:0];
                REG_WIDTH:     r_frame_width  <= i_cfg_data[SIDE_W-1:0];
                REG_HEIGHT:    r_frame_height <= i_cfg_data[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_t2 <= T2_W'(r_threshold) * T2_W'(r_threshold);
    end

    // Points per frame, and the position of the incoming point. A position
    // left beyond the frame by a size change starts over at zero.
    always_comb begin
        side_prod = PROD_W'(clamp_side(r_frame_width))
                  * PROD_W'(clamp_side(r_frame_height));
        npts      = (side_prod > PROD_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(side_prod);
        cur_idx   = ({1'b0, r_count} >= npts) ? '0 : r_count;
        nxt_idx   = {1'b0, cur_idx} + CNT_W'(1);
        wrap      = (nxt_idx >= npts);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_bg_ready <= 1'b0;
        end else if (accept) begin
            if (wrap) begin
                r_count    <= '0;
                r_bg_ready <= 1'b1;
            end else begin
                r_count <= nxt_idx[ADDR_W-1:0];
            end
        end
    end

    // Single-port background memory: written during the capture frame,
    // read during every later frame. The read register holds while stalled.
    always_ff @(posedge i_clk) begin
        if (accept && !r_bg_ready) begin
            r_bg_mem[cur_idx] <= {i_finite, i_pos_z, i_pos_y, i_pos_x};
        end
        if (en) begin
            r_bg_rd <= r_bg_mem[cur_idx];
        end
    end

    // Read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (en) begin
            r_s1_ctl.valid <= accept;
            r_s1_ctl.flag  <= accept && r_bg_ready && i_finite;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x      <= i_pos_x;
            r_s1_y      <= i_pos_y;
            r_s1_z      <= i_pos_z;
            r_s1_colour <= i_colour;
            r_s1_idx    <= cur_idx;
        end
    end

    // Squared distance and threshold test.
    pcbs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_s1_ctl),
        .i_cur_x (r_s1_x),
        .i_cur_y (r_s1_y),
        .i_cur_z (r_s1_z),
        .i_bg    (r_bg_rd),
        .i_t2    (r_t2),
        .o_ctl   (s2_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_x      <= r_s1_x;
            r_s2_y      <= r_s1_y;
            r_s2_z      <= r_s1_z;
            r_s2_colour <= r_s1_colour;
            r_s2_idx    <= r_s1_idx;
        end
    end

    // Output register: only foreground points are presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s2_ctl.valid && s2_ctl.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x      <= r_s2_x;
            r_out_y      <= r_s2_y;
            r_out_z      <= r_s2_z;
            r_out_colour <= r_s2_colour;
            r_out_idx    <= r_s2_idx;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_z       = r_out_z;
    assign o_out_colour  = r_out_colour;
    assign o_point_index = INDEX_W'(r_out_idx);

`ifndef NO_ASSERTIONS
    // A result can only exist once the background has been captured.
    a_out_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_bg_ready)
        else $error("foreground result during capture frame");

    // Points of the capture frame are never compared.
    a_capture_no_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_bg_ready) |=> !r_s1_ctl.flag)
        else $error("capture point marked for comparison");

    // A compare request always belongs to a real point.
    a_flag_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_ctl.flag || r_s1_ctl.valid) && (!s2_ctl.flag || s2_ctl.valid))
        else $error("pipeline flag without a point");

    // A held result freezes the pipeline stages behind it.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_s1_ctl) && $stable(r_count)))
        else $error("pipeline moved while output was stalled");
`endif

endmodule

FILE: bench/tb_point_cloud_background_subtract.sv
`timescale 1ns / 1ps

// Self-checking bench for the point-cloud background subtraction block.
// The bench keeps its own copy of the background, the frame position and the
// registers, works out for every accepted point whether it must come out as
// foreground, and checks every output transfer against the oldest such
// expectation, field by field.
module tb_point_cloud_background_subtract;
    import pcbs_pkg::*;

    // Share of cycles in which either side idles, in percent.
    localparam int GAP_PCT     = 38;
    // Length of the single long output hold-off.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any transfer after which the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed for the pipeline to empty when no result is pending.
    localparam int SETTLE      = 8;
    // The configuration index space has one code beyond the three registers.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COLOUR_W-1:0]       colour;
        logic                      finite;
    } t_point;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COLOUR_W-1:0]       colour;
        logic [INDEX_W-1:0]        index;
    } t_fg_point;

    // Clock, reset and the block's ports. Each input starts at a known value.
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic signed [COORD_W-1:0]  pos_x      = '0;
    logic signed [COORD_W-1:0]  pos_y      = '0;
    logic signed [COORD_W-1:0]  pos_z      = '0;
    logic [COLOUR_W-1:0]        colour     = '0;
    logic                       finite     = 1'b0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic [COLOUR_W-1:0]        out_colour;
    logic [INDEX_W-1:0]         point_index;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;

    // Bench copy of the block's state and registers. Only entries written by
    // the capture frame are ever read back.
    logic [BG_W-1:0]            bg_copy [MAX_POINTS];
    logic                       bg_ready   = 1'b0;
    int unsigned                frame_pos  = 0;
    logic [THR_W-1:0]           thr_mm     = THR_RESET;
    logic [SIDE_W-1:0]          width_reg  = WIDTH_RESET;
    logic [SIDE_W-1:0]          height_reg = HEIGHT_RESET;

    // Points waiting to be sent and foreground points waiting to come out.
    t_point                     point_queue[$];
    t_point                     cur_point;
    t_fg_point                  foreground_due[$];

    int                         points_sent = 0;
    int                         fg_checked  = 0;
    int                         cfg_writes  = 0;
    int                         errors      = 0;
    int                         quiet       = 0;

    // Flow control knobs set by the stimulus and the receiver, read by both.
    bit                         no_gaps     = 1'b0;
    bit                         hold_wanted = 1'b0;
    bit                         hold_done   = 1'b0;
    int                         hold_left   = 0;

    point_cloud_background_subtract dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_pos_z       (pos_z),
        .i_colour      (colour),
        .i_finite      (finite),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_x       (out_x),
        .o_out_y       (out_y),
        .o_out_z       (out_z),
        .o_out_colour  (out_colour),
        .o_point_index (point_index),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A frame side of zero counts as one, anything above 1024 as 1024.
    function automatic int unsigned side_of(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > SIDE_MAX) begin
            return SIDE_MAX;
        end
        return 32'(v);
    endfunction

    // Points per frame, capped at the depth of the background memory.
    function automatic int unsigned frame_points();
        longint unsigned n;
        n = longint'(side_of(width_reg)) * longint'(side_of(height_reg));
        if (n > MAX_POINTS) begin
            n = MAX_POINTS;
        end
        return 32'(n);
    endfunction

    function automatic logic signed [COORD_W-1:0] clip(input int v);
        if (v > 32767) begin
            return COORD_W'(32767);
        end
        if (v < -32768) begin
            return COORD_W'(-32768);
        end
        return COORD_W'(v);
    endfunction

    function automatic t_point mk(input int x, input int y, input int z,
                                  input int unsigned rgb, input bit fin);
        t_point pt;
        pt.x      = clip(x);
        pt.y      = clip(y);
        pt.z      = clip(z);
        pt.colour = COLOUR_W'(rgb);
        pt.finite = fin;
        return pt;
    endfunction

    // Appends a point to the send queue.
    function automatic void add_point(input t_point pt);
        point_queue = {point_queue, pt};
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Stores the point while the background is being captured, otherwise
    // decides whether it is foreground and queues the expected output.
    task automatic classify_point(input t_point pt);
        int unsigned     n;
        int unsigned     p;
        logic [BG_W-1:0] e;
        longint          dx;
        longint          dy;
        longint          dz;
        t_fg_point       fg;
        n = frame_points();
        p = (frame_pos >= n) ? 0 : frame_pos;
        if (!bg_ready) begin
            bg_copy[p] = {pt.finite, pt.z, pt.y, pt.x};
        end else begin
            e = bg_copy[p];
            if (pt.finite && e[BG_W-1]) begin
                dx = longint'(pt.x) - longint'($signed(e[COORD_W-1:0]));
                dy = longint'(pt.y) - longint'($signed(e[2*COORD_W-1:COORD_W]));
                dz = longint'(pt.z) - longint'($signed(e[3*COORD_W-1:2*COORD_W]));
                // The squared distance is compared exactly; 64 bits hold it.
                if (dx * dx + dy * dy + dz * dz > longint'(thr_mm) * longint'(thr_mm)) begin
                    fg.x      = pt.x;
                    fg.y      = pt.y;
                    fg.z      = pt.z;
                    fg.colour = pt.colour;
                    fg.index  = INDEX_W'(p);
                    foreground_due = {foreground_due, fg};
                end
            end
        end
        p++;
        if (p >= n) begin
            p        = 0;
            bg_ready = 1'b1;
        end
        frame_pos = p;
    endtask

    // Queues points for the current frame setting. Each point is built
    // around the stored background at the position it will land on, so that
    // the mix holds points well inside the threshold, points around it,
    // points exactly at it and one beyond, unrelated points and missing
    // points. The wild mix is mostly unrelated points, which almost always
    // come out at a low threshold and rarely at the highest one.
    task automatic queue_points(input int count, input bit wild);
        int unsigned     n;
        int unsigned     p;
        int unsigned     rgb;
        int              axis[3];
        int              thr;
        int              span;
        int              pick;
        int              mag;
        int              k;
        logic [BG_W-1:0] e;
        n   = frame_points();
        p   = frame_pos;
        thr = int'(thr_mm);
        repeat (count) begin
            if (p >= n) begin
                p = 0;
            end
            e       = bg_copy[p];
            axis[0] = $signed(e[COORD_W-1:0]);
            axis[1] = $signed(e[2*COORD_W-1:COORD_W]);
            axis[2] = $signed(e[3*COORD_W-1:2*COORD_W]);
            rgb     = $urandom_range(24'hFFFFFF);
            if (wild) begin
                pick = ($urandom_range(9) == 0) ? 95 : 80;
            end else begin
                pick = $urandom_range(99);
            end
            if (pick < 75) begin
                // Close to the background, or within about twice the threshold.
                span = (pick < 40) ? thr / 2 : 2 * thr + 2;
                for (k = 0; k < 3; k++) begin
                    axis[k] += int'($urandom_range(2 * span)) - span;
                end
            end else if (pick < 85 || pick >= 93) begin
                for (k = 0; k < 3; k++) begin
                    axis[k] = rand_coord();
                end
            end else begin
                // Exactly at the threshold along one axis, or one beyond it.
                k   = $urandom_range(2);
                mag = thr + int'($urandom_range(1));
                axis[k] += $urandom_range(1) ? mag : -mag;
            end
            add_point(mk(axis[0], axis[1], axis[2], rgb, pick < 93));
            p++;
            if (p >= n) begin
                p = 0;
            end
        end
    endtask

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_mm     = data;
            REG_WIDTH:     width_reg  = data[SIDE_W-1:0];
            REG_HEIGHT:    height_reg = data[SIDE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Waits until every queued point has gone in and every expected
    // foreground point has come out, then lets the pipeline run empty.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (point_queue.size() != 0 || in_valid || foreground_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic bit field_differs(input string name, input longint want,
                                         input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Point sender. A transfer that completes at this edge is classified
    // first; then, if the slot is free, the next point is offered or the
    // sender idles. A stalled point stays on the pins unchanged.
    always @(posedge i_clk) begin
        if (in_valid && !in_stall) begin
            classify_point(cur_point);
            points_sent++;
        end
        if (!in_valid || !in_stall) begin
            if (point_queue.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                cur_point = point_queue.pop_front();
                in_valid <= 1'b1;
                pos_x    <= cur_point.x;
                pos_y    <= cur_point.y;
                pos_z    <= cur_point.z;
                colour   <= cur_point.colour;
                finite   <= cur_point.finite;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output receiver. It stalls at random except while no_gaps is set, and
    // once for a long stretch that it counts down itself.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
        end
    end

    // Output checker.
    always @(posedge i_clk) begin : check_output
        t_fg_point want;
        bit        bad;
        if (i_rst_n && out_valid && !out_stall) begin
            if (foreground_due.size() == 0) begin
                $display("%0t: foreground point not expected, expected none, actual index %0d",
                         $time, point_index);
                errors++;
            end else begin
                want = foreground_due.pop_front();
                bad  = 1'b0;
                bad |= field_differs("out_x", want.x, out_x);
                bad |= field_differs("out_y", want.y, out_y);
                bad |= field_differs("out_z", want.z, out_z);
                bad |= field_differs("out_colour", want.colour, out_colour);
                bad |= field_differs("point_index", want.index, point_index);
                if (bad) begin
                    errors++;
                end
                fg_checked++;
            end
        end
    end

    // Watchdog: the run is hung if no transfer of any kind happens for a
    // long time.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("[point_cloud_background_subtract] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        int unsigned p;
        int          v;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Background capture: one row of 512 points. The first positions get
        // the coordinate extremes, a missing point and a fixed point that the
        // directed points below are measured against.
        write_reg(REG_WIDTH, 16'd512);
        write_reg(REG_HEIGHT, 16'd1);
        for (p = 0; p < 512; p++) begin
            if (p < 3) begin
                v = (p == 0) ? -32768 : (p == 1) ? 32767 : 0;
                add_point(mk(v, v, v, $urandom_range(24'hFFFFFF), 1'b1));
            end else if (p == 3) begin
                add_point(mk(5000, -5000, 5000, $urandom_range(24'hFFFFFF), 1'b0));
            end else if (p < 10) begin
                add_point(mk(100, -200, 300, $urandom_range(24'hFFFFFF), 1'b1));
            end else begin
                add_point(mk(rand_coord(), rand_coord(), rand_coord(),
                             $urandom_range(24'hFFFFFF), $urandom_range(7) != 0));
            end
        end
        wait_idle();

        // Directed points at the reset threshold of 600 mm.
        add_point(mk(32767, 32767, 32767, 24'hFFFFFF, 1'b1));     // widest gap
        add_point(mk(-32768, -32768, -32768, 24'h000000, 1'b1));  // widest gap
        add_point(mk(600, 0, 0, 24'h123456, 1'b1));     // exactly at threshold
        add_point(mk(-9000, 9000, 0, 24'h654321, 1'b1));  // background missing
        add_point(mk(9000, 0, 0, 24'hA5A5A5, 1'b0));    // current point missing
        add_point(mk(100, -200, 300, 24'h5A5A5A, 1'b1));  // no movement
        add_point(mk(701, -200, 300, 24'h0F0F0F, 1'b1));  // one mm beyond, x
        add_point(mk(100, -801, 300, 24'hF0F0F0, 1'b1));  // one mm beyond, y
        add_point(mk(100, -200, 900, 24'h00FF00, 1'b1));  // exactly at threshold
        add_point(mk(447, 147, 647, 24'hFF00FF, 1'b1));   // just beyond, diagonal
        queue_points(200, 1'b0);
        wait_idle();

        // Zero threshold with a tall, narrow frame. The receiver holds off
        // for a long stretch while points keep coming, so the block fills up.
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1024);
        no_gaps     = 1'b1;
        hold_wanted = 1'b1;
        queue_points(150, 1'b1);
        wait_idle();
        no_gaps = 1'b0;

        // Largest threshold; all-ones sides give the memory-capped frame. The
        // write to the unused index must leave every register alone.
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(CFG_NO_REG, 16'h0001);
        queue_points(100, 1'b1);
        wait_idle();

        // Zero sides make a one-point frame; the frame position left over
        // from before is out of range and the next point lands on position 0.
        write_reg(REG_THRESHOLD, 16'd1);
        write_reg(REG_WIDTH, 16'hF800);
        write_reg(REG_HEIGHT, 16'd0);
        queue_points(50, 1'b0);
        wait_idle();

        // Small frame that wraps many times.
        write_reg(REG_THRESHOLD, 16'd300);
        write_reg(REG_WIDTH, 16'd7);
        write_reg(REG_HEIGHT, 16'd5);
        queue_points(140, 1'b0);
        wait_idle();

        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(3000, 50)));
        write_reg(REG_WIDTH, 16'd32);
        write_reg(REG_HEIGHT, 16'd32);
        queue_points(100, 1'b0);
        wait_idle();

        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(20000, 1000)));
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd200);
        queue_points(100, 1'b0);
        wait_idle();

        $display("Sent %0d points (512 captured as background), checked %0d foreground points,",
                 points_sent, fg_checked);
        $display("made %0d register writes over seven frame settings, %0d mismatching outputs.",
                 cfg_writes, errors);
        if (errors == 0) begin
            $display("[point_cloud_background_subtract] OK");
        end else begin
            $display("[point_cloud_background_subtract] ERROR");
        end
        $finish;
    end

endmodule
